// File: hw/rtl/fhfa_pkg.sv
// Package for the free hole fit allocator.
// Holds sequencer states, item, strategy and status codes and the compare flags.
// No dependencies.
`timescale 1ns / 1ps

package fhfa_pkg;

	// Item mode codes
	localparam logic MODE_FREE  = 1'b0;
	localparam logic MODE_ALLOC = 1'b1;

	// Fit strategy codes (the unused code behaves as first fit)
	localparam logic [1:0] FIT_FIRST = 2'd0;
	localparam logic [1:0] FIT_BEST  = 2'd1;
	localparam logic [1:0] FIT_WORST = 2'd2;

	// Result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NOFIT = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_CMP,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_REM_RD,
		S_REM_WR,
		S_DONE
	} state_t;

	// Outcome of comparing a table entry size against the key size
	typedef struct packed {
		logic ge;
		logic gt;
		logic lt;
	} cmp_flags_t;

endpackage

// File: hw/rtl/fhfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the hole table. No dependencies.
`timescale 1ns / 1ps

module fhfa_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: hw/rtl/fhfa_alu.sv
// Shared compare, subtract and offset add unit of the allocator.
// Depends on fhfa_pkg for the compare flag struct.
`timescale 1ns / 1ps

module fhfa_alu #(
	parameter int OFFSET_BITS = 32,
	parameter int SIZE_BITS   = 16
) (
	input  logic [OFFSET_BITS-1:0]   entry_off,
	input  logic [SIZE_BITS-1:0]     entry_size,
	input  logic [SIZE_BITS-1:0]     key_size,
	output fhfa_pkg::cmp_flags_t     flags,
	output logic [SIZE_BITS-1:0]     diff,
	output logic [OFFSET_BITS-1:0]   sum_off
);
	import fhfa_pkg::*;

	localparam int SUM_W = OFFSET_BITS + SIZE_BITS;

	logic [SUM_W-1:0] sum_full;

	// Compare entry against key
	always_comb begin
		flags.ge = (entry_size >= key_size);
		flags.gt = (entry_size > key_size);
		flags.lt = (entry_size < key_size);
	end

	// Remainder size after a grant
	assign diff = entry_size - key_size;

	// Remainder offset, wrapping at the offset width
	assign sum_full = SUM_W'(entry_off) + SUM_W'(key_size);
	assign sum_off  = sum_full[OFFSET_BITS-1:0];

endmodule

// File: hw/rtl/free_hole_fit_allocator.sv
// Free hole table allocator with first, best and worst fit.
// Depends on fhfa_pkg, fhfa_ram and fhfa_alu.
//
// Channel   Handshake              Payload
// req       req_valid / req_stall  mode, item_offset, item_size
// rsp       rsp_valid / rsp_stall  status, alloc_offset
// cfg       cfg_valid / cfg_ready  fit_strategy
//
// One item at a time; the table sits in a RAM with one read and one write port.
// Free: appended at the end; under best or worst fit a sorted insert moves entries up.
// Allocate: scan from the front to the first fitting hole, move later entries down, then
// free any remainder. A miss scans all entries, or stops if worst fit rejects the front.
// The result waits in an output register; a new item is taken meanwhile.
// Reset clears state, hole count, index, strategy and response valid; no pass clears the RAM.
`timescale 1ns / 1ps

module free_hole_fit_allocator #(
	parameter int CAPACITY    = 64,
	parameter int OFFSET_BITS = 32,
	parameter int SIZE_BITS   = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// request channel
	input  logic                   req_valid,
	output logic                   req_stall,
	input  logic                   mode,
	input  logic [OFFSET_BITS-1:0] item_offset,
	input  logic [SIZE_BITS-1:0]   item_size,
	// response channel
	output logic                   rsp_valid,
	input  logic                   rsp_stall,
	output logic [1:0]             status,
	output logic [OFFSET_BITS-1:0] alloc_offset,
	// configuration channel
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [1:0]             fit_strategy
);
	import fhfa_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int ENT_W = OFFSET_BITS + SIZE_BITS;

	state_t state_q, state_d;

	logic [1:0]             strat_q;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       idx_q;
	logic [OFFSET_BITS-1:0] key_off_q;
	logic [SIZE_BITS-1:0]   key_size_q;
	logic [1:0]             res_status_q;
	logic [OFFSET_BITS-1:0] res_grant_q;
	logic                   rsp_valid_q;
	logic [1:0]             rsp_status_q;
	logic [OFFSET_BITS-1:0] rsp_offset_q;

	logic                   ram_we;
	logic [IDX_W-1:0]       ram_waddr;
	logic [ENT_W-1:0]       ram_wdata;
	logic [IDX_W-1:0]       ram_raddr;
	logic [ENT_W-1:0]       ram_rdata;
	logic [OFFSET_BITS-1:0] rd_off;
	logic [SIZE_BITS-1:0]   rd_size;

	cmp_flags_t             flags;
	logic [SIZE_BITS-1:0]   diff;
	logic [OFFSET_BITS-1:0] sum_off;

	logic                   is_best;
	logic                   is_worst;
	logic                   direct_ins;
	logic                   shift_up;
	logic                   table_full;
	logic                   rem_last;
	logic                   rsp_load;
	logic [CNT_W-1:0]       idx_m1;
	logic [CNT_W-1:0]       idx_p1;

	assign rd_off     = ram_rdata[ENT_W-1:SIZE_BITS];
	assign rd_size    = ram_rdata[SIZE_BITS-1:0];
	assign is_best    = (strat_q == FIT_BEST);
	assign is_worst   = (strat_q == FIT_WORST);
	assign idx_m1     = idx_q - CNT_W'(1);
	assign idx_p1     = idx_q + CNT_W'(1);
	assign direct_ins = (!is_best && !is_worst) || (idx_q == '0);
	assign shift_up   = is_best ? flags.gt : flags.lt;
	assign table_full = (count_q == CNT_W'(CAPACITY));
	assign rem_last   = (idx_p1 >= count_q);

	// Hole table: offset in the upper bits, size in the lower bits
	fhfa_ram #(
		.WIDTH (ENT_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Shared compare and add unit, always fed by the entry just read
	fhfa_alu #(
		.OFFSET_BITS (OFFSET_BITS),
		.SIZE_BITS   (SIZE_BITS)
	) u_alu (
		.entry_off  (rd_off),
		.entry_size (rd_size),
		.key_size   (key_size_q),
		.flags      (flags),
		.diff       (diff),
		.sum_off    (sum_off)
	);

	// Next state and RAM port control
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = idx_q[IDX_W-1:0];
		ram_wdata = {key_off_q, key_size_q};
		ram_raddr = idx_q[IDX_W-1:0];
		rsp_load  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					if (mode == MODE_ALLOC) begin
						state_d = S_SRCH_RD;
					end else if (table_full) begin
						state_d = S_DONE;
					end else begin
						state_d = S_INS_RD;
					end
				end
			end
			S_INS_RD: begin
				if (direct_ins) begin
					ram_we  = 1'b1;
					state_d = S_DONE;
				end else begin
					ram_raddr = idx_m1[IDX_W-1:0];
					state_d   = S_INS_CMP;
				end
			end
			S_INS_CMP: begin
				ram_we = 1'b1;
				if (shift_up) begin
					ram_wdata = ram_rdata;
					state_d   = S_INS_RD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SRCH_RD: begin
				if (idx_q == count_q) begin
					state_d = S_DONE;
				end else begin
					state_d = S_SRCH_CMP;
				end
			end
			S_SRCH_CMP: begin
				if (flags.ge) begin
					state_d = S_REM_RD;
				end else if (is_worst) begin
					state_d = S_DONE;
				end else begin
					state_d = S_SRCH_RD;
				end
			end
			S_REM_RD: begin
				if (rem_last) begin
					state_d = (key_size_q != '0) ? S_INS_RD : S_DONE;
				end else begin
					ram_raddr = idx_p1[IDX_W-1:0];
					state_d   = S_REM_WR;
				end
			end
			S_REM_WR: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata;
				state_d   = S_REM_RD;
			end
			S_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers: state, hole count, scan index, strategy, response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			strat_q     <= FIT_FIRST;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				strat_q <= fit_strategy;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						idx_q <= (mode == MODE_ALLOC) ? '0 : count_q;
					end
				end
				S_INS_RD: begin
					if (direct_ins) begin
						count_q <= count_q + CNT_W'(1);
					end
				end
				S_INS_CMP: begin
					if (shift_up) begin
						idx_q <= idx_m1;
					end else begin
						count_q <= count_q + CNT_W'(1);
					end
				end
				S_SRCH_CMP: begin
					if (!flags.ge && !is_worst) begin
						idx_q <= idx_p1;
					end
				end
				S_REM_RD: begin
					if (rem_last) begin
						count_q <= count_q - CNT_W'(1);
						idx_q   <= count_q - CNT_W'(1);
					end
				end
				S_REM_WR: begin
					idx_q <= idx_p1;
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers: key hole, pending result, response output
	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_status_q <= res_status_q;
			rsp_offset_q <= res_grant_q;
		end
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					key_off_q    <= item_offset;
					key_size_q   <= item_size;
					res_grant_q  <= '0;
					res_status_q <= (mode == MODE_FREE && table_full) ? ST_FULL : ST_OK;
				end
			end
			S_SRCH_RD: begin
				if (idx_q == count_q) begin
					res_status_q <= ST_NOFIT;
				end
			end
			S_SRCH_CMP: begin
				if (flags.ge) begin
					// take the hole; keep the remainder as the next key
					key_off_q   <= sum_off;
					key_size_q  <= diff;
					res_grant_q <= rd_off;
				end else if (is_worst) begin
					res_status_q <= ST_NOFIT;
				end
			end
			default: begin
			end
		endcase
	end

	assign req_stall    = (state_q != S_IDLE);
	assign cfg_ready    = 1'b1;
	assign rsp_valid    = rsp_valid_q;
	assign status       = rsp_status_q;
	assign alloc_offset = rsp_offset_q;

endmodule

// File: hw/rtl/fhfa_chk.sv
// Port-level checker for the free hole fit allocator, bound to the top level.
// Depends on fhfa_pkg for status codes.
`timescale 1ns / 1ps

module fhfa_chk #(
	parameter int OFFSET_BITS = 32,
	parameter int SIZE_BITS   = 16
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   req_valid,
	input logic                   req_stall,
	input logic                   rsp_valid,
	input logic                   rsp_stall,
	input logic [1:0]             status,
	input logic [OFFSET_BITS-1:0] alloc_offset
);
	import fhfa_pkg::*;

	// Hold a stalled response
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(alloc_offset))
		else $error("stalled response changed");

	// Grant only on success
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_OK |-> alloc_offset == '0)
		else $error("failed item returned an offset");

	// Block the request side after a transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("second request taken while busy");

	// Raise a response only at the end of item work
	a_rsp_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("response appeared without item work");

endmodule

bind free_hole_fit_allocator fhfa_chk #(
	.OFFSET_BITS (OFFSET_BITS),
	.SIZE_BITS   (SIZE_BITS)
) u_fhfa_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req_valid),
	.req_stall    (req_stall),
	.rsp_valid    (rsp_valid),
	.rsp_stall    (rsp_stall),
	.status       (status),
	.alloc_offset (alloc_offset)
);
